@@ rtl/core/wsdf_pkg.sv @@
// Shared types and constants for the WebSocket text frame deframer.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package wsdf_pkg;

  // Frame completion status carried with frame_done
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LEN64   = 2'd1,
    ST_LONG    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  localparam logic [3:0] OPCODE_TEXT   = 4'h1;
  localparam logic [6:0] LEN7_EXT16    = 7'd126;
  localparam logic [6:0] LEN7_EXT64    = 7'd127;
  localparam logic [7:0] CHAR_FIRST    = 8'd32;
  localparam logic [7:0] CHAR_LAST     = 8'd126;
  localparam logic [7:0] CHAR_TAB      = 8'd9;
  localparam logic [7:0] CHAR_LF       = 8'd10;
  localparam logic [7:0] CHAR_CR       = 8'd13;
  localparam logic [6:0] CHAR_SPACE    = 7'd32;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd512;

  // One received word as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       timed_out;
  } in_item_t;

  // One result word; emit marks that the step produced a result
  typedef struct packed {
    logic       emit;
    logic       char_valid;
    logic [6:0] char_value;
    logic       frame_done;
    status_e    status;
  } result_t;

endpackage

@@ rtl/core/wsdf_in_stage.sv @@
// Input register of the deframer: captures one received word per cycle when not stalled.
// Depends on wsdf_pkg for the in_item_t word type.
`timescale 1ns / 1ps

module wsdf_in_stage import wsdf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     advance_i,
  output logic     item_valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  // Hold while a word sits here and the parser cannot take it
  assign in_stall_o   = valid_q && !advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

@@ rtl/core/wsdf_parser.sv @@
// Frame header parser, unmasking and text filter for one word per cycle when not stalled.
// Depends on wsdf_pkg for word, result and status types.
`timescale 1ns / 1ps

module wsdf_parser import wsdf_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  in_item_t    item_i,
  input  logic [15:0] max_payload_i,
  output result_t     res_o
);

  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_EXTHI = 3'd2;
  localparam logic [2:0] PH_EXTLO = 3'd3;
  localparam logic [2:0] PH_MASK  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;

  localparam logic [16:0] LenCap = 17'((1 << LENGTH_BITS) - 1);

  logic [2:0]             phase_q, phase_d;
  logic [3:0]             opcode_q, opcode_d;
  logic                   masked_q, masked_d;
  logic [LENGTH_BITS-1:0] plen_q, plen_d;
  logic [LENGTH_BITS-1:0] bcnt_q, bcnt_d;
  logic [31:0]            key_q, key_d;
  logic [7:0]             ext_hi_q, ext_hi_d;

  always_comb begin
    logic [7:0]             b;
    logic [15:0]            len_in;
    logic                   do_len;
    logic [7:0]             kb;
    logic [7:0]             v;
    logic [LENGTH_BITS-1:0] bnext;
    logic                   keep;
    logic [6:0]             ch;
    phase_d  = phase_q;
    opcode_d = opcode_q;
    masked_d = masked_q;
    plen_d   = plen_q;
    bcnt_d   = bcnt_q;
    key_d    = key_q;
    ext_hi_d = ext_hi_q;
    res_o    = '0;
    b        = item_i.data_byte;
    len_in   = '0;
    do_len   = 1'b0;
    kb       = '0;
    v        = '0;
    bnext    = '0;
    keep     = 1'b0;
    ch       = '0;
    if (fire_i) begin
      if (item_i.timed_out) begin
        // Abort only a frame in progress; idle timeouts vanish
        if (phase_q inside {PH_HDR1, PH_EXTHI, PH_EXTLO, PH_MASK, PH_DATA}) begin
          phase_d          = PH_HDR0;
          res_o.emit       = 1'b1;
          res_o.frame_done = 1'b1;
          res_o.status     = ST_TIMEOUT;
        end
      end else begin
        case (phase_q)
          PH_HDR1: begin
            masked_d = b[7];
            key_d    = '0;
            plen_d   = '0;
            bcnt_d   = '0;
            if (b[6:0] == LEN7_EXT16) begin
              phase_d = PH_EXTHI;
            end else if (b[6:0] == LEN7_EXT64) begin
              phase_d          = PH_HDR0;
              res_o.emit       = 1'b1;
              res_o.frame_done = 1'b1;
              res_o.status     = ST_LEN64;
            end else begin
              len_in = {9'd0, b[6:0]};
              do_len = 1'b1;
            end
          end
          PH_EXTHI: begin
            ext_hi_d = b;
            phase_d  = PH_EXTLO;
          end
          PH_EXTLO: begin
            len_in = {ext_hi_q, b};
            do_len = 1'b1;
          end
          PH_MASK: begin
            key_d = {key_q[23:0], b};
            if (bcnt_q[1:0] == 2'd3) begin
              bcnt_d = '0;
              if (plen_q == '0) begin
                phase_d          = PH_HDR0;
                res_o.emit       = 1'b1;
                res_o.frame_done = 1'b1;
                res_o.status     = ST_OK;
              end else begin
                phase_d = PH_DATA;
              end
            end else begin
              bcnt_d = bcnt_q + 1'b1;
            end
          end
          PH_DATA: begin
            case (bcnt_q[1:0])
              2'd0:    kb = key_q[31:24];
              2'd1:    kb = key_q[23:16];
              2'd2:    kb = key_q[15:8];
              default: kb = key_q[7:0];
            endcase
            v      = b ^ kb;
            bnext  = bcnt_q + 1'b1;
            bcnt_d = bnext;
            if (opcode_q == OPCODE_TEXT) begin
              if (v >= CHAR_FIRST && v <= CHAR_LAST) begin
                keep = 1'b1;
                ch   = v[6:0];
              end else if (v == CHAR_LF || v == CHAR_CR || v == CHAR_TAB) begin
                keep = 1'b1;
                ch   = CHAR_SPACE;
              end
            end
            res_o.char_valid = keep;
            res_o.char_value = ch;
            if (bnext >= plen_q) begin
              phase_d          = PH_HDR0;
              res_o.emit       = 1'b1;
              res_o.frame_done = 1'b1;
              res_o.status     = ST_OK;
            end else begin
              res_o.emit = keep;
            end
          end
          default: begin
            // First header byte; unknown phases land here too
            opcode_d = b[3:0];
            phase_d  = PH_HDR1;
          end
        endcase

        if (do_len) begin
          if (len_in > max_payload_i || {1'b0, len_in} > LenCap) begin
            phase_d          = PH_HDR0;
            res_o.emit       = 1'b1;
            res_o.frame_done = 1'b1;
            res_o.status     = ST_LONG;
          end else begin
            plen_d = len_in[LENGTH_BITS-1:0];
            bcnt_d = '0;
            if (masked_d) begin
              phase_d = PH_MASK;
            end else if (len_in == '0) begin
              phase_d          = PH_HDR0;
              res_o.emit       = 1'b1;
              res_o.frame_done = 1'b1;
              res_o.status     = ST_OK;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opcode_q <= '0;
      masked_q <= 1'b0;
      plen_q   <= '0;
      bcnt_q   <= '0;
      key_q    <= '0;
      ext_hi_q <= '0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      plen_q   <= plen_d;
      bcnt_q   <= bcnt_d;
      key_q    <= key_d;
      ext_hi_q <= ext_hi_d;
    end
  end

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_DATA)
    else $error("parser phase out of range");

  a_timeout_to_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.timed_out |=> phase_q == PH_HDR0)
    else $error("timeout did not return parser to header phase");

  a_error_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.emit && res_o.status != ST_OK |-> res_o.frame_done && !res_o.char_valid)
    else $error("error status without frame end");

  a_mask_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_MASK |-> bcnt_q < LENGTH_BITS'(4))
    else $error("mask byte count overran key");

  a_no_silent_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.char_valid |-> res_o.emit && $past(phase_q) != PH_MASK || res_o.emit)
    else $error("kept character not emitted");

endmodule

@@ rtl/core/wsdf_out_stage.sv @@
// Result register of the deframer: holds one result word until taken.
// Depends on wsdf_pkg for the result_t word type.
`timescale 1ns / 1ps

module wsdf_out_stage import wsdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  result_t    res_i,
  output logic       advance_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       char_valid_o,
  output logic [6:0] char_value_o,
  output logic       frame_done_o,
  output logic [1:0] status_o
);

  logic    valid_q;
  result_t res_q;

  // Advance whenever the held word is gone or leaves this cycle
  assign advance_o    = !valid_q || !out_stall_i;
  assign out_valid_o  = valid_q;
  assign char_valid_o = res_q.char_valid;
  assign char_value_o = res_q.char_value;
  assign frame_done_o = res_q.frame_done;
  assign status_o     = res_q.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= fire_i && res_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && fire_i && res_i.emit) begin
      res_q <= res_i;
    end
  end

endmodule

@@ rtl/core/websocket_text_frame_deframer.sv @@
// WebSocket text frame deframer: takes one received byte per cycle when not stalled and
// returns the text characters of text frames plus one frame-end word per frame.
// Throughput is one byte per clock while the output is not stalled. An accepted byte
// is held in the input register, and the parser result for it is captured in the
// result register, which drives the outputs. Bytes that give no result (header bytes,
// dropped characters, payload of other opcodes) produce no output word. A stall on the
// output holds a full result register, and in_stall_o follows it in the same cycle once
// the input register is full too. max_payload is written through cfg_we_i / cfg_wdata_i;
// the user must write it only while the block is idle; the block does not enforce this.
// It resets to 512. Frames that fail report a nonzero status with frame_done, and the
// consumer must discard the text already received for that frame; the block cannot.
// Depends on wsdf_pkg, wsdf_in_stage, wsdf_parser and wsdf_out_stage.
`timescale 1ns / 1ps

module websocket_text_frame_deframer import wsdf_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        timed_out_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        char_valid_o,
  output logic [6:0]  char_value_o,
  output logic        frame_done_o,
  output logic [1:0]  status_o
);

  logic [15:0] max_payload_q;
  in_item_t    in_item;
  in_item_t    item;
  logic        item_valid;
  logic        advance;
  logic        fire;
  result_t     res;

  assign in_item.data_byte = data_byte_i;
  assign in_item.timed_out = timed_out_i;
  assign fire              = item_valid && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  wsdf_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  wsdf_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (item),
    .max_payload_i (max_payload_q),
    .res_o         (res)
  );

  wsdf_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .res_i        (res),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_valid_o (char_valid_o),
    .char_value_o (char_value_o),
    .frame_done_o (frame_done_o),
    .status_o     (status_o)
  );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for websocket_text_frame_deframer: random and directed
// byte streams, a cycle-free frame parser predictor and field-by-field word checks.
// Depends on wsdf_pkg and the deframer RTL.
`timescale 1ns / 1ps

module testbench import wsdf_pkg::*; ();

  localparam int          LENGTH_BITS = 16;
  localparam int unsigned LEN_CAP     = (32'd1 << LENGTH_BITS) - 1;
  localparam int          QUIET_LIMIT = 2000;
  localparam logic [15:0] MAX_SET [7] = '{16'hFFFF, 16'd0, 16'd1, 16'd20, 16'd126, 16'd700,
                                          16'd512};

  typedef enum logic [2:0] {PH_HDR0, PH_HDR1, PH_EXTHI, PH_EXTLO, PH_MASK, PH_DATA}
    parse_phase_e;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_value;
    logic       frame_done;
    status_e    status;
  } word_t;

  typedef struct {
    logic [7:0]  data;
    logic        to;
    bit          drain;
    int unsigned gap;
  } rx_byte_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        timed_out_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        char_valid_o;
  logic [6:0]  char_value_o;
  logic        frame_done_o;
  logic [1:0]  status_o;

  websocket_text_frame_deframer #(.LENGTH_BITS(LENGTH_BITS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .timed_out_i  (timed_out_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_valid_o (char_valid_o),
    .char_value_o (char_value_o),
    .frame_done_o (frame_done_o),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  rx_byte_t    rx_bytes[$];
  word_t       expected_words[$];
  bit          idle_on = 1'b1;
  int unsigned n_queued, n_bytes, n_chars, n_fail, hold_left, quiet;
  int unsigned n_status[4];

  // Parser state mirrored from the block
  parse_phase_e ph       = PH_HDR0;
  logic [3:0]   op_q     = '0;
  logic         masked_q = 1'b0;
  logic [15:0]  plen     = '0;
  int unsigned  bcnt     = 0;
  logic [31:0]  key_q    = '0;
  logic [15:0]  max_len  = MAX_PAYLOAD_RST;

  function automatic word_t done_word(input status_e st);
    word_t w;
    w = '0;
    w.frame_done = 1'b1;
    w.status = st;
    return w;
  endfunction

  function automatic bit length_known(input logic [15:0] len, output word_t w);
    w = '0;
    if (len > max_len || 32'(len) > LEN_CAP) begin
      ph = PH_HDR0;
      w = done_word(ST_LONG);
      return 1'b1;
    end
    plen = len;
    bcnt = 0;
    if (masked_q) begin
      ph = PH_MASK;
      return 1'b0;
    end
    if (len == 0) begin
      ph = PH_HDR0;
      w = done_word(ST_OK);
      return 1'b1;
    end
    ph = PH_DATA;
    return 1'b0;
  endfunction

  // Advance the parser by one accepted word; return 1 when a result word follows
  function automatic bit deframe_byte(input logic [7:0] b, input logic to, output word_t w);
    logic [7:0] v;
    logic [6:0] ch;
    bit         keep;
    bit         last;
    w = '0;
    if (to) begin
      if (ph == PH_HDR0) return 1'b0;
      ph = PH_HDR0;
      w = done_word(ST_TIMEOUT);
      return 1'b1;
    end
    case (ph)
      PH_HDR0: begin
        op_q = b[3:0];
        ph = PH_HDR1;
        return 1'b0;
      end
      PH_HDR1: begin
        masked_q = b[7];
        key_q = '0;
        plen = '0;
        bcnt = 0;
        if (b[6:0] == LEN7_EXT16) begin
          ph = PH_EXTHI;
          return 1'b0;
        end
        if (b[6:0] == LEN7_EXT64) begin
          ph = PH_HDR0;
          w = done_word(ST_LEN64);
          return 1'b1;
        end
        return length_known({9'd0, b[6:0]}, w);
      end
      PH_EXTHI: begin
        plen = {b, 8'h00};
        ph = PH_EXTLO;
        return 1'b0;
      end
      PH_EXTLO: return length_known({plen[15:8], b}, w);
      PH_MASK: begin
        key_q = {key_q[23:0], b};
        bcnt = (bcnt + 1) & 7;
        if (bcnt >= 4) begin
          bcnt = 0;
          if (plen == 0) begin
            ph = PH_HDR0;
            w = done_word(ST_OK);
            return 1'b1;
          end
          ph = PH_DATA;
        end
        return 1'b0;
      end
      default: begin
        // unmask with the key byte picked by position mod 4, first key byte on top
        v = b ^ 8'(key_q >> (24 - 8 * (bcnt & 3)));
        bcnt = (bcnt + 1) & LEN_CAP;
        last = bcnt >= plen;
        keep = 1'b0;
        ch = '0;
        if (op_q == OPCODE_TEXT) begin
          if (v >= CHAR_FIRST && v <= CHAR_LAST) begin
            keep = 1'b1;
            ch = v[6:0];
          end else if (v == CHAR_LF || v == CHAR_CR || v == CHAR_TAB) begin
            keep = 1'b1;
            ch = CHAR_SPACE;
          end
        end
        w.char_valid = keep;
        w.char_value = ch;
        if (last) begin
          ph = PH_HDR0;
          w.frame_done = 1'b1;
          w.status = ST_OK;
          return 1'b1;
        end
        return keep;
      end
    endcase
  endfunction

  // Sender: hold a stalled word; otherwise wait out its gap or a pending drain, then present the next one
  always @(posedge clk_i) begin : send_words
    word_t    w;
    rx_byte_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (deframe_byte(data_byte_i, timed_out_i, w)) expected_words.push_back(w);
        n_bytes++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (rx_bytes.size() == 0 || (rx_bytes[0].drain && expected_words.size() != 0)) begin
          in_valid_i <= 1'b0;
        end else if (rx_bytes[0].gap != 0) begin
          rx_bytes[0].gap = rx_bytes[0].gap - 1;
          in_valid_i <= 1'b0;
        end else begin
          nxt = rx_bytes.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= nxt.data;
          timed_out_i <= nxt.to;
        end
      end
    end
  end

  // Receiver: check each accepted word against the oldest expectation and stall the output at random while idle_on
  always @(posedge clk_i) begin : take_words
    word_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: char_valid %0d char_value %0d frame_done %0d status %0d",
                 char_valid_o, char_value_o, frame_done_o, status_o);
          n_fail++;
        end else begin
          e = expected_words.pop_front();
          if (char_valid_o !== e.char_valid) begin
            $error("char_valid: expected %0d, got %0d", e.char_valid, char_valid_o);
            n_fail++;
          end
          if (char_value_o !== e.char_value) begin
            $error("char_value: expected %0d, got %0d", e.char_value, char_value_o);
            n_fail++;
          end
          if (frame_done_o !== e.frame_done) begin
            $error("frame_done: expected %0d, got %0d", e.frame_done, frame_done_o);
            n_fail++;
          end
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o);
            n_fail++;
          end
          if (e.char_valid) n_chars++;
          if (e.frame_done) n_status[e.status]++;
        end
        hold_left = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("[websocket_text_frame_deframer] ERROR");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic to, input bit drain);
    rx_byte_t x;
    x.data = b;
    x.to = to;
    x.drain = drain;
    x.gap = idle_on ? $urandom_range(0, 3) : 0;
    rx_bytes.push_back(x);
    n_queued++;
  endtask

  // Wait until every word is sent and answered, then let the pipeline empty
  task automatic settle();
    do @(negedge clk_i);
    while (rx_bytes.size() != 0 || in_valid_i || expected_words.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_max_payload(input logic [15:0] v);
    settle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_len = v;
  endtask

  // One frame, mostly well formed; sometimes noise, a 64-bit length, or a cut with timeout
  task automatic add_frame();
    logic [7:0]  fr[$];
    logic [31:0] mkey;
    logic [3:0]  opc;
    logic [7:0]  plain;
    logic [15:0] len;
    int unsigned r, n_pay, cut, i;
    bit          masked, ext, force_cut;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      return;
    end
    opc = ($urandom_range(0, 9) < 6) ? OPCODE_TEXT : 4'($urandom_range(0, 15));
    masked = 1'($urandom_range(0, 1));
    mkey = (!masked || $urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
    r = $urandom_range(0, 99);
    if (r < 50) len = 16'($urandom_range(0, 12));
    else if (r < 65) len = 16'($urandom_range(13, 125));
    else if (r < 75) len = max_len;
    else if (r < 83) len = (max_len == 16'hFFFF) ? max_len : max_len + 16'd1;
    else if (r < 90) len = 16'($urandom_range(126, 300));
    else len = 16'($urandom_range(0, 65535));
    ext = (len > 125) || ($urandom_range(0, 7) == 0);
    force_cut = 1'b0;
    fr.push_back({4'($urandom_range(0, 15)), opc});
    if ($urandom_range(0, 29) == 0) begin
      fr.push_back({masked, LEN7_EXT64});
    end else begin
      fr.push_back({masked, ext ? LEN7_EXT16 : len[6:0]});
      if (ext) begin
        fr.push_back(len[15:8]);
        fr.push_back(len[7:0]);
      end
      if (len <= max_len) begin
        if (masked) for (i = 0; i < 4; i++) fr.push_back(mkey[31 - 8 * i -: 8]);
        n_pay = 32'(len);
        if (len > 160 || (len > 40 && $urandom_range(0, 3) != 0)) begin
          n_pay = $urandom_range(0, 20);
          force_cut = 1'b1;
        end
        for (i = 0; i < n_pay; i++) begin
          r = $urandom_range(0, 99);
          if (r < 60) plain = 8'($urandom_range(32, 126));
          else if (r < 75) begin
            case ($urandom_range(0, 2))
              0: plain = CHAR_TAB;
              1: plain = CHAR_LF;
              default: plain = CHAR_CR;
            endcase
          end else if (r < 85) plain = 8'($urandom_range(0, 31));
          else if (r < 90) plain = 8'd127;
          else plain = 8'($urandom_range(128, 255));
          fr.push_back(plain ^ mkey[31 - 8 * (i % 4) -: 8]);
        end
      end
    end
    cut = fr.size();
    if (!force_cut && $urandom_range(0, 11) == 0) cut = $urandom_range(0, fr.size() - 1);
    for (i = 0; i < cut; i++) push_byte(fr[i], 1'b0, $urandom_range(0, 49) == 0);
    if (force_cut || cut < fr.size()) push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  initial begin : stimulus
    int unsigned k, target;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // timeout with no frame open
    push_byte(8'hFF, 1'b1, 1'b0);
    // empty unmasked text frame
    push_byte(8'h81, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    // 64-bit length code
    push_byte(8'h82, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    // 16-bit length 65535, over the reset limit
    push_byte(8'h01, 1'b0, 1'b0);
    push_byte({1'b0, LEN7_EXT16}, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    // empty masked frame: done on the last key byte
    push_byte(8'h89, 1'b0, 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);
    repeat (4) push_byte(8'h00, 1'b0, 1'b0);
    // masked text: 'A', tab, a dropped NUL, then '~' kept on the last byte
    push_byte(8'h81, 1'b0, 1'b0);
    push_byte(8'h84, 1'b0, 1'b0);
    push_byte(8'hAA, 1'b0, 1'b0);
    push_byte(8'h55, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h41 ^ 8'hAA, 1'b0, 1'b0);
    push_byte(CHAR_TAB ^ 8'h55, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h7E ^ 8'hFF, 1'b0, 1'b0);
    // binary frame cut short; hold the timeout until all results are in
    push_byte(8'h02, 1'b0, 1'b0);
    push_byte(8'h03, 1'b0, 1'b0);
    push_byte(8'h41, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b1);

    for (k = 0; k < 7; k++) begin
      set_max_payload((k == 5) ? 16'($urandom_range(2, 65534)) : MAX_SET[k]);
      idle_on = (k % 3 != 2);
      target = n_queued + 75;
      while (n_queued < target) add_frame();
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      n_fail++;
    end
    $display("%0d bytes sent over 8 max_payload settings, %0d text characters checked",
             n_bytes, n_chars);
    $display("frames ended: %0d ok, %0d 64-bit length, %0d too long, %0d timeout",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (n_fail == 0) begin
      $display("[websocket_text_frame_deframer] OK");
    end else begin
      $display("[websocket_text_frame_deframer] ERROR");
    end
    $finish;
  end

endmodule

@@ websocket_text_frame_deframer.f @@
rtl/core/wsdf_pkg.sv
rtl/core/wsdf_in_stage.sv
rtl/core/wsdf_parser.sv
rtl/core/wsdf_out_stage.sv
rtl/core/websocket_text_frame_deframer.sv
verif/testbench.sv
